// ----- hdl/ramped_hbridge_pwm_drive_top_assert.svh -----
// assertion macros for the ramped h-bridge pwm drive
`ifndef RAMPED_HBRIDGE_PWM_DRIVE_TOP_ASSERT_SVH
`define RAMPED_HBRIDGE_PWM_DRIVE_TOP_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define RHB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rhb assertion failed");

// antecedent holds, consequent holds in the next cycle
`define RHB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rhb assertion failed");

`endif

// ----- hdl/rhb_pkg.sv -----
// shared types and constants for the ramped h-bridge pwm drive
`default_nettype none

package rhb_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int MAX_RES_BITS = 15;

  localparam int RES_W  = 4;
  localparam int STEP_W = 23;
  localparam int LVL_W  = 24;
  localparam int POS_W  = 26;
  localparam int DUTY_W = 15;
  localparam int WH_W   = POS_W - FRAC_BITS;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = STEP_W;

  localparam logic [RES_W-1:0]  RES_RESET  = RES_W'(8);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(653);

  localparam logic [CFG_IDX_W-1:0] CFG_RES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 1'b1;

  localparam logic KIND_TARGET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [1:0] RAMP_IDLE = 2'd0;
  localparam logic [1:0] RAMP_RISE = 2'd1;
  localparam logic [1:0] RAMP_FALL = 2'd2;

  localparam logic [1:0] BRIDGE_OFF = 2'd0;
  localparam logic [1:0] BRIDGE_FWD = 2'd1;
  localparam logic [1:0] BRIDGE_REV = 2'd2;

  typedef struct packed {
    logic [RES_W-1:0]  res_bits;
    logic [STEP_W-1:0] ramp_step;
  } rhb_cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] ramp_pos;
    logic signed [LVL_W-1:0] applied;
    logic signed [LVL_W-1:0] goal;
    logic [1:0]              ramp_dir;
    logic [1:0]              bridge_dir;
    logic [DUTY_W-1:0]       duty;
  } rhb_state_t;

  typedef struct packed {
    logic [DUTY_W-1:0] plus_duty;
    logic [DUTY_W-1:0] minus_duty;
    logic [1:0]        bridge_state;
    logic              level_changed;
    logic              ramp_active;
  } rhb_result_t;

endpackage

`default_nettype wire

// ----- hdl/rhb_step.sv -----
// one ramp step: next drive state and result for one item
`default_nettype none

module rhb_step (
  input  rhb_pkg::rhb_cfg_t                cfg_i,
  input  logic                             kind_i,
  input  logic signed [rhb_pkg::LVL_W-1:0] target_i,
  input  rhb_pkg::rhb_state_t              state_i,
  output rhb_pkg::rhb_state_t              state_o,
  output rhb_pkg::rhb_result_t             result_o
);

  localparam int PW = rhb_pkg::POS_W;
  localparam int LW = rhb_pkg::LVL_W;
  localparam int FB = rhb_pkg::FRAC_BITS;
  localparam int WW = rhb_pkg::WH_W;
  localparam logic signed [PW-1:0] ONE_Q  = PW'(1) << FB;
  localparam logic signed [PW-1:0] MONE_Q = -(PW'(1) << FB);
  localparam logic [FB-1:0]        HALF_Q = FB'(1) << (FB - 1);

  logic [rhb_pkg::RES_W-1:0] res_sat;
  logic [PW-1:0]             lim_u;
  logic signed [PW-1:0]      lim, neg_lim;
  logic signed [PW-1:0]      k;
  logic signed [PW-1:0]      tgt_x, app_x, goal_x, diff;
  logic                      is_target, big;
  logic signed [PW-1:0]      pos_base, pos_step, cand, v, d;
  logic [1:0]                dir_pre, dir_n;
  logic                      do_step, reached, changed, round_up;
  logic signed [LW-1:0]      goal_n;
  logic [PW-1:0]             mag, absd;
  logic [WW-1:0]             whole_r;
  logic [1:0]                bridge_new;

  always_comb begin
    res_sat = (cfg_i.res_bits > rhb_pkg::RES_W'(rhb_pkg::MAX_RES_BITS)) ?
              rhb_pkg::RES_W'(rhb_pkg::MAX_RES_BITS) : cfg_i.res_bits;
    lim_u   = ((PW'(1) << res_sat) - PW'(1)) << FB;
    lim     = signed'(lim_u);
    neg_lim = -lim;
    k = (cfg_i.ramp_step == '0) ? PW'(1) : signed'(PW'(cfg_i.ramp_step));

    tgt_x = signed'({{(PW-LW){target_i[LW-1]}}, target_i});
    app_x = signed'({{(PW-LW){state_i.applied[LW-1]}}, state_i.applied});
    diff  = tgt_x - app_x;
    big   = (diff >= ONE_Q) || (diff <= MONE_Q);
    is_target = (kind_i == rhb_pkg::KIND_TARGET);

    pos_base = is_target ? app_x : state_i.ramp_pos;
    goal_n   = is_target ? target_i : state_i.goal;
    goal_x   = signed'({{(PW-LW){goal_n[LW-1]}}, goal_n});
    if (is_target) begin
      if (big) begin
        dir_pre = (diff > 0) ? rhb_pkg::RAMP_RISE : rhb_pkg::RAMP_FALL;
      end else begin
        dir_pre = rhb_pkg::RAMP_IDLE;
      end
    end else begin
      dir_pre = state_i.ramp_dir;
    end

    do_step = (dir_pre != rhb_pkg::RAMP_IDLE);
    case (dir_pre)
      rhb_pkg::RAMP_RISE: begin
        pos_step = pos_base + k;
        cand     = (pos_step < goal_x) ? pos_step : goal_x;
        reached  = (pos_step >= goal_x);
      end
      default: begin
        pos_step = pos_base - k;
        cand     = (pos_step > goal_x) ? pos_step : goal_x;
        reached  = (pos_step <= goal_x);
      end
    endcase
    dir_n = (do_step && reached) ? rhb_pkg::RAMP_IDLE : dir_pre;

    // clamp to the level limit and test for a change of at least one
    if (cand < neg_lim) begin
      v = neg_lim;
    end else if (cand > lim) begin
      v = lim;
    end else begin
      v = cand;
    end
    d       = app_x - v;
    absd    = (d < 0) ? unsigned'(-d) : unsigned'(d);
    changed = do_step && (absd >= unsigned'(ONE_Q));

    // round half away from zero, not at the limits
    mag      = (v < 0) ? unsigned'(-v) : unsigned'(v);
    round_up = (mag[FB-1:0] >= HALF_Q) && (v > neg_lim) && (v < lim);
    whole_r  = mag[PW-1:FB] + WW'(round_up);
    if (whole_r == '0) begin
      bridge_new = rhb_pkg::BRIDGE_OFF;
    end else if (v < 0) begin
      bridge_new = rhb_pkg::BRIDGE_REV;
    end else begin
      bridge_new = rhb_pkg::BRIDGE_FWD;
    end

    state_o.ramp_pos = do_step ? pos_step : pos_base;
    state_o.goal     = goal_n;
    state_o.ramp_dir = dir_n;
    if (changed) begin
      state_o.applied    = v[LW-1:0];
      state_o.bridge_dir = bridge_new;
      state_o.duty       = whole_r[rhb_pkg::DUTY_W-1:0];
    end else begin
      state_o.applied    = state_i.applied;
      state_o.bridge_dir = state_i.bridge_dir;
      state_o.duty       = state_i.duty;
    end

    result_o.plus_duty  = (state_o.bridge_dir == rhb_pkg::BRIDGE_FWD) ? state_o.duty : '0;
    result_o.minus_duty = (state_o.bridge_dir == rhb_pkg::BRIDGE_REV) ? state_o.duty : '0;
    result_o.bridge_state  = state_o.bridge_dir;
    result_o.level_changed = changed;
    result_o.ramp_active   = (dir_n != rhb_pkg::RAMP_IDLE);
  end

endmodule

`default_nettype wire

// ----- hdl/ramped_hbridge_pwm_drive_top.sv -----
// top level of the ramped h-bridge pwm drive
// the drive state updates as an item moves from the input register into the result register
// throughput: one item per cycle while out_ready_i is high or the result register is empty
// an empty input register takes a new item while the result register waits on out_ready_i
// reset clears the drive state, the ramp and both registers' valid flags
// and restores resolution 8 and ramp step 653
`default_nettype none

module ramped_hbridge_pwm_drive_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rhb_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [rhb_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  kind_i,
  input  logic signed [rhb_pkg::LVL_W-1:0]      target_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [rhb_pkg::DUTY_W-1:0]            plus_duty_o,
  output logic [rhb_pkg::DUTY_W-1:0]            minus_duty_o,
  output logic [1:0]                            bridge_state_o,
  output logic                                  level_changed_o,
  output logic                                  ramp_active_o
);

  `include "ramped_hbridge_pwm_drive_top_assert.svh"

  rhb_pkg::rhb_cfg_t            cfg_q;
  rhb_pkg::rhb_state_t          state_q, state_d;
  rhb_pkg::rhb_result_t         result_d, result_q;
  logic                         in_valid_q;
  logic                         kind_q;
  logic signed [rhb_pkg::LVL_W-1:0] target_q;
  logic                         out_valid_q;
  logic                         advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.res_bits  <= rhb_pkg::RES_RESET;
      cfg_q.ramp_step <= rhb_pkg::STEP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rhb_pkg::CFG_RES:  cfg_q.res_bits  <= cfg_data_i[rhb_pkg::RES_W-1:0];
        rhb_pkg::CFG_STEP: cfg_q.ramp_step <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rhb_step u_step (
    .cfg_i    (cfg_q),
    .kind_i   (kind_q),
    .target_i (target_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q   <= kind_i;
      target_q <= target_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign plus_duty_o     = result_q.plus_duty;
  assign minus_duty_o    = result_q.minus_duty;
  assign bridge_state_o  = result_q.bridge_state;
  assign level_changed_o = result_q.level_changed;
  assign ramp_active_o   = result_q.ramp_active;

  `RHB_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q)
  `RHB_ASSERT_NOW(a_full_stall_blocks, in_valid_q && out_valid_q && !out_ready_i, !in_ready_o)
  `RHB_ASSERT_NOW(a_one_side_driven, out_valid_o, (plus_duty_o == '0) || (minus_duty_o == '0))
  `RHB_ASSERT_NOW(a_off_no_duty, out_valid_o && (bridge_state_o == rhb_pkg::BRIDGE_OFF),
                  (plus_duty_o == '0) && (minus_duty_o == '0))

endmodule

`default_nettype wire

// ----- tb/sv/ramped_hbridge_pwm_drive_checker.sv -----
`timescale 1ns / 100ps
// checker for the ramped h-bridge pwm drive: predicts every result item and compares it
module ramped_hbridge_pwm_drive_checker
  import rhb_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          kind_i,
  input  logic signed [LVL_W-1:0]       target_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [DUTY_W-1:0]             plus_duty_i,
  input  logic [DUTY_W-1:0]             minus_duty_i,
  input  logic [1:0]                    bridge_state_i,
  input  logic                          level_changed_i,
  input  logic                          ramp_active_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam longint LVL_ONE  = longint'(1) << FRAC_BITS;
  localparam longint LVL_HALF = longint'(1) << (FRAC_BITS - 1);

  logic [RES_W-1:0]  res_bits;
  logic [STEP_W-1:0] step_q8;
  longint            ramp_pos;
  longint            applied_lvl;
  longint            goal_lvl;
  logic [1:0]        ramp_dir;
  logic [1:0]        bridge_dir;
  logic [DUTY_W-1:0] duty;
  int                mismatches;
  rhb_result_t       drive_expect_q[$];

  function automatic longint drive_limit();
    int r;
    r = (res_bits > MAX_RES_BITS) ? MAX_RES_BITS : int'(res_bits);
    return ((longint'(1) << r) - 1) * LVL_ONE;
  endfunction

  function automatic bit commit_level(input longint cand);
    longint lim;
    longint gap;
    longint mag;
    longint whole;
    longint lvl;
    lim = drive_limit();
    if (cand < -lim) begin
      cand = -lim;
    end else if (cand > lim) begin
      cand = lim;
    end
    gap = applied_lvl - cand;
    if (gap < 0) begin
      gap = -gap;
    end
    if (gap < LVL_ONE) begin
      return 1'b0;
    end
    applied_lvl = cand;
    mag = (cand < 0) ? -cand : cand;
    whole = mag >>> FRAC_BITS;
    if ((mag - (whole << FRAC_BITS)) >= LVL_HALF && cand > -lim && cand < lim) begin
      whole++;
    end
    lvl = (cand < 0) ? -whole : whole;
    if (lvl > 0) begin
      bridge_dir = BRIDGE_FWD;
      duty = DUTY_W'(lvl);
    end else if (lvl < 0) begin
      bridge_dir = BRIDGE_REV;
      duty = DUTY_W'(-lvl);
    end else begin
      bridge_dir = BRIDGE_OFF;
      duty = '0;
    end
    return 1'b1;
  endfunction

  function automatic bit advance_ramp();
    longint stride;
    bit moved;
    stride = (step_q8 == '0) ? 1 : longint'(step_q8);
    if (ramp_dir == RAMP_RISE) begin
      ramp_pos += stride;
      moved = commit_level((ramp_pos < goal_lvl) ? ramp_pos : goal_lvl);
      if (ramp_pos >= goal_lvl) begin
        ramp_dir = RAMP_IDLE;
      end
    end else begin
      ramp_pos -= stride;
      moved = commit_level((ramp_pos > goal_lvl) ? ramp_pos : goal_lvl);
      if (ramp_pos <= goal_lvl) begin
        ramp_dir = RAMP_IDLE;
      end
    end
    return moved;
  endfunction

  function automatic rhb_result_t predict_drive(input logic kind,
                                                input logic signed [LVL_W-1:0] tgt);
    rhb_result_t res;
    longint diff;
    bit moved;
    moved = 1'b0;
    if (kind == KIND_TARGET) begin
      goal_lvl = longint'(tgt);
      diff = goal_lvl - applied_lvl;
      ramp_pos = applied_lvl;
      if (diff >= LVL_ONE || diff <= -LVL_ONE) begin
        ramp_dir = (diff > 0) ? RAMP_RISE : RAMP_FALL;
        moved = advance_ramp();
      end else begin
        ramp_dir = RAMP_IDLE;
      end
    end else if (ramp_dir != RAMP_IDLE) begin
      moved = advance_ramp();
    end
    res.plus_duty     = (bridge_dir == BRIDGE_FWD) ? duty : '0;
    res.minus_duty    = (bridge_dir == BRIDGE_REV) ? duty : '0;
    res.bridge_state  = bridge_dir;
    res.level_changed = moved;
    res.ramp_active   = (ramp_dir != RAMP_IDLE);
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rhb_result_t want;
    if (!rst_ni) begin
      res_bits    = RES_RESET;
      step_q8     = STEP_RESET;
      ramp_pos    = 0;
      applied_lvl = 0;
      goal_lvl    = 0;
      ramp_dir    = RAMP_IDLE;
      bridge_dir  = BRIDGE_OFF;
      duty        = '0;
      mismatches  = 0;
      drive_expect_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_RES) begin
          res_bits = cfg_data_i[RES_W-1:0];
        end else if (cfg_index_i == CFG_STEP) begin
          step_q8 = cfg_data_i[STEP_W-1:0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (drive_expect_q.size() == 0) begin
          $error("result item with no item pending");
          mismatches++;
        end else begin
          want = drive_expect_q.pop_front();
          check_field("plus_duty", want.plus_duty, plus_duty_i);
          check_field("minus_duty", want.minus_duty, minus_duty_i);
          check_field("bridge_state", want.bridge_state, bridge_state_i);
          check_field("level_changed", want.level_changed, level_changed_i);
          check_field("ramp_active", want.ramp_active, ramp_active_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        drive_expect_q.push_back(predict_drive(kind_i, target_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= drive_expect_q.size();
    end
  end

endmodule

// ----- tb/sv/ramped_hbridge_pwm_drive_top_tb.sv -----
`timescale 1ns / 100ps
// testbench top for the ramped h-bridge pwm drive: stimulus, flow control and verdict
module ramped_hbridge_pwm_drive_top_tb;
  import rhb_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 10;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    kind_i;
  logic signed [LVL_W-1:0] target_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [DUTY_W-1:0]       plus_duty_o;
  logic [DUTY_W-1:0]       minus_duty_o;
  logic [1:0]              bridge_state_o;
  logic                    level_changed_o;
  logic                    ramp_active_o;

  int                      fail_count;
  int                      pending;
  int                      send_idle_pct;
  int                      recv_idle_pct;
  bit                      hold_req;
  int                      items_sent;
  int                      cycles;
  logic signed [LVL_W-1:0] last_goal;

  ramped_hbridge_pwm_drive_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .target_i       (target_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .plus_duty_o    (plus_duty_o),
    .minus_duty_o   (minus_duty_o),
    .bridge_state_o (bridge_state_o),
    .level_changed_o(level_changed_o),
    .ramp_active_o  (ramp_active_o)
  );

  ramped_hbridge_pwm_drive_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .kind_i         (kind_i),
    .target_i       (target_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .plus_duty_i    (plus_duty_o),
    .minus_duty_i   (minus_duty_o),
    .bridge_state_i (bridge_state_o),
    .level_changed_i(level_changed_o),
    .ramp_active_i  (ramp_active_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic signed [LVL_W-1:0] pick_target(input int res);
    longint lim;
    longint span;
    longint v;
    int sel;
    lim = ((longint'(1) << res) - 1) << FRAC_BITS;
    span = lim + 512;
    sel = $urandom_range(99);
    if (sel < 35) begin
      v = longint'($urandom_range(32'(2 * span))) - span;
    end else if (sel < 55) begin
      return LVL_W'($urandom);
    end else if (sel < 70) begin
      v = longint'(last_goal) + longint'($urandom_range(600)) - 300;
    end else if (sel < 80) begin
      case ($urandom_range(6))
        0: v = 8388607;
        1: v = -8388608;
        2: v = lim;
        3: v = -lim;
        4: v = lim + 1;
        5: v = -lim - 1;
        default: v = 0;
      endcase
    end else begin
      v = (longint'($urandom_range(32'(2 * (lim >>> 7) + 2))) - (lim >>> 7) - 1) * 128
          + longint'($urandom_range(2)) - 1;
    end
    if (v > 8388607) begin
      v = 8388607;
    end else if (v < -8388608) begin
      v = -8388608;
    end
    return LVL_W'(v);
  endfunction

  task automatic send_item(input logic kind, input logic [LVL_W-1:0] tgt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    target_i   <= tgt;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic load_cfg(input int res, input int step);
    logic [CFG_DATA_W-1:0] res_word;
    drain();
    res_word = CFG_DATA_W'(($urandom << RES_W) | res);
    cfg_valid_i <= 1'b1;
    for (int idx = 0; idx < 2; idx++) begin
      cfg_index_i <= (idx == 0) ? CFG_RES : CFG_STEP;
      cfg_data_i  <= (idx == 0) ? res_word : CFG_DATA_W'(step);
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input int res, input int step, input int count,
                           input int s_idle, input int r_idle, input bit hold);
    int stop_at;
    int ticks;
    logic signed [LVL_W-1:0] tgt;
    load_cfg(res, step);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    hold_req = hold;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 8) begin
        send_item(1'($urandom), LVL_W'($urandom));
      end else begin
        tgt = pick_target(res);
        send_item(KIND_TARGET, tgt);
        last_goal = tgt;
        ticks = $urandom_range(($urandom_range(3) == 0) ? 60 : 8);
        repeat (ticks) send_item(KIND_TICK, LVL_W'($urandom));
      end
    end
  endtask

  initial begin : sink
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("ramped_hbridge_pwm_drive_top_tb failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_RES;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_TARGET;
    target_i      = '0;
    out_ready_i   = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 81;
    hold_req      = 1'b0;
    items_sent    = 0;
    last_goal     = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // short ramps at a low limit: rounding, small changes, clamping
    load_cfg(4, 1000);
    send_item(KIND_TICK, 24'h555555);
    send_item(KIND_TARGET, 24'sd100);
    send_item(KIND_TARGET, 24'sd640);
    send_item(KIND_TARGET, 24'sd50);
    send_item(KIND_TARGET, 24'sd0);
    send_item(KIND_TARGET, -24'sd640);
    send_item(KIND_TARGET, -24'sd639);
    send_item(KIND_TARGET, 24'sd0);
    send_item(KIND_TARGET, 24'sh7FFFFF);
    repeat (4) send_item(KIND_TICK, 24'hAAAAAA);
    send_item(KIND_TARGET, 24'sh800000);
    repeat (6) send_item(KIND_TICK, 24'h000000);
    send_item(KIND_TARGET, 24'sd3967);
    repeat (2) send_item(KIND_TICK, 24'hFFFFFF);

    run_phase(15, 8388352, 220, 16, 81, 1'b0);
    run_phase(1, 1, 220, 16, 81, 1'b0);
    run_phase(0, 0, 200, 16, 81, 1'b1);
    run_phase(15, 0, 220, 81, 16, 1'b0);
    run_phase(8, 653, 220, 81, 16, 1'b0);
    run_phase(10, $urandom_range(4000, 1), 220, 81, 16, 1'b0);
    run_phase(12, $urandom_range(70000, 100), 220, 0, 0, 1'b1);
    run_phase(15, $urandom_range(8388352, 1), 220, 0, 0, 1'b0);
    run_phase(3, 300, 200, 0, 0, 1'b1);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ramped_hbridge_pwm_drive_top_tb passed");
    end else begin
      $display("ramped_hbridge_pwm_drive_top_tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rhb_pkg.sv
hdl/rhb_step.sv
hdl/ramped_hbridge_pwm_drive_top.sv
tb/sv/ramped_hbridge_pwm_drive_checker.sv
tb/sv/ramped_hbridge_pwm_drive_top_tb.sv
